>>> hdl/ttd_pkg.sv
`timescale 1ns / 1ps
package ttd_pkg;

    localparam int MAX_DIM_DEF   = 1024;
    localparam int PAL_DEPTH_DEF = 256;
    localparam int XY_W          = 15;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_PAL   = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;

    localparam logic [3:0] FMT_I4     = 4'd0;
    localparam logic [3:0] FMT_I8     = 4'd1;
    localparam logic [3:0] FMT_IA4    = 4'd2;
    localparam logic [3:0] FMT_IA8    = 4'd3;
    localparam logic [3:0] FMT_RGB565 = 4'd4;
    localparam logic [3:0] FMT_RGB5A3 = 4'd5;
    localparam logic [3:0] FMT_RGBA8  = 4'd6;
    localparam logic [3:0] FMT_C4     = 4'd7;
    localparam logic [3:0] FMT_C8     = 4'd8;
    localparam logic [3:0] FMT_CMPR   = 4'd9;

    localparam logic [2:0] REG_TEX_FMT   = 3'd0;
    localparam logic [2:0] REG_WIDTH     = 3'd1;
    localparam logic [2:0] REG_HEIGHT    = 3'd2;
    localparam logic [2:0] REG_PAL_FMT   = 3'd3;
    localparam logic [2:0] REG_PAL_COUNT = 3'd4;
    localparam logic [2:0] REG_PAL_BE    = 3'd5;

    typedef struct packed {
        logic [3:0]  fmt;
        logic [10:0] width;
        logic [10:0] height;
        logic [1:0]  pal_fmt;
        logic [8:0]  pal_count;
        logic        pal_be;
    } t_cfg;

    typedef struct packed {
        logic            is_wr;
        logic [3:0]      fmt;
        logic [7:0]      d;
        logic [7:0]      held;
        logic [7:0]      idx;
        logic [15:0]     aux;
        logic [15:0]     e0;
        logic [15:0]     e1;
        logic [XY_W-1:0] x;
        logic [XY_W-1:0] y;
        logic [3:0]      mask;
    } t_job;

endpackage

>>> hdl/ttd_front.sv
`timescale 1ns / 1ps
module ttd_front #(
    parameter int MAX_DIMENSION = ttd_pkg::MAX_DIM_DEF,
    parameter int PALETTE_DEPTH = ttd_pkg::PAL_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ttd_pkg::t_cfg i_cfg,
    input  logic          i_accept,
    input  logic [1:0]    i_cmd,
    input  logic [7:0]    i_data,
    input  logic [7:0]    i_extra,
    input  logic [7:0]    i_index,
    output logic          o_push,
    output ttd_pkg::t_job o_job
);
    localparam int XW = ttd_pkg::XY_W;
    localparam int CW = $clog2((MAX_DIMENSION + 3) / 4 + 1);
    localparam logic [XW-1:0] MAXV = XW'(MAX_DIMENSION);

    logic [CW-1:0] r_col, n_col, r_row, n_row;
    logic [5:0]    r_bib, n_bib;
    logic [7:0]    r_held, n_held;
    logic [15:0]   r_e0, n_e0, r_e1, n_e1;
    logic [15:0]   r_ar [16];
    logic          ar_we;
    logic [3:0]    ar_addr;

    logic [XW-1:0] wv, hv, bx, by, xo, yo, across, down, col1, row1;
    logic          wide8, tall8, rgba, active, pix;
    logic [5:0]    b;
    logic [6:0]    nb;
    logic [2:0]    npix;

    always_comb begin
        wv = (XW'(i_cfg.width) > MAXV) ? MAXV : XW'(i_cfg.width);
        hv = (XW'(i_cfg.height) > MAXV) ? MAXV : XW'(i_cfg.height);
        wide8 = (i_cfg.fmt == ttd_pkg::FMT_I4) || (i_cfg.fmt == ttd_pkg::FMT_C4) ||
                (i_cfg.fmt == ttd_pkg::FMT_CMPR) || (i_cfg.fmt == ttd_pkg::FMT_I8) ||
                (i_cfg.fmt == ttd_pkg::FMT_IA4) || (i_cfg.fmt == ttd_pkg::FMT_C8);
        tall8 = (i_cfg.fmt == ttd_pkg::FMT_I4) || (i_cfg.fmt == ttd_pkg::FMT_C4) ||
                (i_cfg.fmt == ttd_pkg::FMT_CMPR);
        rgba = (i_cfg.fmt == ttd_pkg::FMT_RGBA8);
        b = rgba ? r_bib : {1'b0, r_bib[4:0]};
        bx = wide8 ? (XW'(r_col) << 3) : (XW'(r_col) << 2);
        by = tall8 ? (XW'(r_row) << 3) : (XW'(r_row) << 2);
        across = wide8 ? ((wv + XW'(7)) >> 3) : ((wv + XW'(3)) >> 2);
        down = tall8 ? ((hv + XW'(7)) >> 3) : ((hv + XW'(3)) >> 2);
        col1 = XW'(r_col) + XW'(1);
        row1 = XW'(r_row) + XW'(1);
        nb = {1'b0, b} + 7'd1;
        active = i_accept && (i_cmd == ttd_pkg::CMD_BYTE) &&
                 (i_cfg.fmt <= ttd_pkg::FMT_CMPR) && (wv != '0) && (hv != '0);

        n_col = r_col;
        n_row = r_row;
        n_bib = r_bib;
        n_held = r_held;
        n_e0 = r_e0;
        n_e1 = r_e1;
        ar_we = 1'b0;
        ar_addr = b[4:1];
        xo = bx;
        yo = by;
        npix = 3'd0;
        pix = 1'b0;
        o_job = '0;
        o_job.fmt = i_cfg.fmt;
        o_job.d = i_data;
        o_job.held = r_held;
        o_job.e0 = r_e0;
        o_job.e1 = r_e1;
        o_job.aux = r_ar[b[4:1]];
        o_job.idx = i_index;

        if (active) begin
            unique case (i_cfg.fmt)
                ttd_pkg::FMT_I4, ttd_pkg::FMT_C4: begin
                    xo = bx + XW'({b[1:0], 1'b0});
                    yo = by + XW'(b[4:2]);
                    npix = 3'd2;
                    pix = 1'b1;
                end
                ttd_pkg::FMT_I8, ttd_pkg::FMT_IA4, ttd_pkg::FMT_C8: begin
                    xo = bx + XW'(b[2:0]);
                    yo = by + XW'(b[4:3]);
                    npix = 3'd1;
                    pix = 1'b1;
                end
                ttd_pkg::FMT_IA8, ttd_pkg::FMT_RGB565, ttd_pkg::FMT_RGB5A3: begin
                    if (!b[0]) begin
                        n_held = i_data;
                    end else begin
                        xo = bx + XW'(b[2:1]);
                        yo = by + XW'(b[4:3]);
                        npix = 3'd1;
                        pix = 1'b1;
                    end
                end
                ttd_pkg::FMT_RGBA8: begin
                    if (!b[0]) begin
                        n_held = i_data;
                    end else if (!b[5]) begin
                        ar_we = 1'b1;
                    end else begin
                        xo = bx + XW'(b[2:1]);
                        yo = by + XW'(b[4:3]);
                        npix = 3'd1;
                        pix = 1'b1;
                    end
                end
                default: begin
                    if (b[2:0] == 3'd0 || b[2:0] == 3'd2) begin
                        n_held = i_data;
                    end else if (b[2:0] == 3'd1) begin
                        n_e0 = {r_held, i_data};
                    end else if (b[2:0] == 3'd3) begin
                        n_e1 = {r_held, i_data};
                    end else begin
                        xo = bx + XW'({b[3], 2'b00});
                        yo = by + XW'({b[4], b[1:0]});
                        npix = 3'd4;
                        pix = 1'b1;
                    end
                end
            endcase

            if (nb >= (rgba ? 7'd64 : 7'd32)) begin
                n_bib = '0;
                if (col1 >= across) begin
                    n_col = '0;
                    n_row = (row1 >= down) ? '0 : CW'(row1);
                end else begin
                    n_col = CW'(col1);
                end
            end else begin
                n_bib = nb[5:0];
            end
        end

        for (int k = 0; k < 4; k++) begin
            o_job.mask[k] = (3'(k) < npix) && ((xo + XW'(k)) < wv) && (yo < hv);
        end
        o_job.x = xo;
        o_job.y = yo;

        o_push = 1'b0;
        if (i_accept && i_cmd == ttd_pkg::CMD_PAL &&
            {24'd0, i_index} < 32'(PALETTE_DEPTH)) begin
            o_job.is_wr = 1'b1;
            o_job.aux = {i_data, i_extra};
            o_push = 1'b1;
        end else if (pix && (|o_job.mask)) begin
            o_push = 1'b1;
        end

        if (i_accept && i_cmd == ttd_pkg::CMD_START) begin
            n_col = '0;
            n_row = '0;
            n_bib = '0;
            n_held = '0;
            n_e0 = '0;
            n_e1 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_bib <= '0;
            r_held <= '0;
            r_e0 <= '0;
            r_e1 <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            r_bib <= n_bib;
            r_held <= n_held;
            r_e0 <= n_e0;
            r_e1 <= n_e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ar_we) begin
            r_ar[ar_addr] <= {r_held, i_data};
        end
    end

endmodule

>>> hdl/ttd_queue.sv
`timescale 1ns / 1ps
module ttd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ttd_pkg::t_job i_job,
    input  logic          i_pop,
    output ttd_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    localparam int AW = $clog2(ttd_pkg::QUEUE_DEPTH);

    ttd_pkg::t_job r_mem [ttd_pkg::QUEUE_DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    assign o_full = (r_cnt == (AW+1)'(ttd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + AW'(1);
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> hdl/ttd_back.sv
`timescale 1ns / 1ps
module ttd_back #(
    parameter int PALETTE_DEPTH = ttd_pkg::PAL_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ttd_pkg::t_cfg i_cfg,
    input  logic          i_q_valid,
    input  ttd_pkg::t_job i_q_job,
    output logic          o_q_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [55:0]   o_data,
    output logic          o_last
);
    localparam int PAW = $clog2(PALETTE_DEPTH);

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
    } t_rgba;

    function automatic logic [7:0] ex5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic t_rgba dec565(input logic [15:0] v);
        t_rgba c;
        c.r = ex5(v[15:11]);
        c.g = {v[10:5], v[10:9]};
        c.b = ex5(v[4:0]);
        c.a = 8'hFF;
        return c;
    endfunction

    function automatic t_rgba dec5a3(input logic [15:0] v);
        t_rgba c;
        if (v[15]) begin
            c.r = ex5(v[14:10]);
            c.g = ex5(v[9:5]);
            c.b = ex5(v[4:0]);
            c.a = 8'hFF;
        end else begin
            c.r = {v[11:8], v[11:8]};
            c.g = {v[7:4], v[7:4]};
            c.b = {v[3:0], v[3:0]};
            c.a = {v[14:12], v[14:12], v[14:13]};
        end
        return c;
    endfunction

    function automatic logic [7:0] blend(input logic [7:0] p, input logic [7:0] s);
        logic [10:0] t;
        t = 11'(p) * 11'd5 + 11'(s) * 11'd3;
        return t[10:3];
    endfunction

    function automatic logic [7:0] avg(input logic [7:0] p, input logic [7:0] s);
        logic [8:0] t;
        t = 9'(p) + 9'(s);
        return t[8:1];
    endfunction

    logic [15:0]   r_pal [PALETTE_DEPTH];
    ttd_pkg::t_job r_job, r_s1;
    logic [3:0]    r_mask;
    logic          r_s1_v, r_s1_last;
    logic [1:0]    r_s1_k;
    logic [15:0]   r_pal_q;
    logic          r_out_v, r_out_last;
    logic [55:0]   r_out_data;

    logic          busy, s1_move, s1_load, take;
    logic [1:0]    k;
    logic [3:0]    rest;
    logic [3:0]    nib, s_nib;
    logic [7:0]    pidx, lidx;
    logic [8:0]    pcount;
    logic [15:0]   pv, v16;
    logic [1:0]    cidx;
    t_rgba         pc, c, c0, c1;
    ttd_pkg::t_job s1_job;

    always_comb begin
        busy = |r_mask;
        s1_move = r_s1_v && (!r_out_v || i_ready);
        s1_load = !r_s1_v || s1_move;
        take = busy && s1_load;
        priority if (r_mask[0]) begin
            k = 2'd0;
        end else if (r_mask[1]) begin
            k = 2'd1;
        end else if (r_mask[2]) begin
            k = 2'd2;
        end else begin
            k = 2'd3;
        end
        rest = r_mask & ~(4'b0001 << k);
        o_q_pop = i_q_valid && (!busy || (take && rest == '0));
        nib = (k == 2'd0) ? r_job.d[7:4] : r_job.d[3:0];
        pidx = (r_job.fmt == ttd_pkg::FMT_C4) ? {4'd0, nib} : r_job.d;
        s1_job = r_job;
        s1_job.x = r_job.x + ttd_pkg::XY_W'(k);
    end

    always_comb begin
        s_nib = (r_s1_k == 2'd0) ? r_s1.d[7:4] : r_s1.d[3:0];
        lidx = (r_s1.fmt == ttd_pkg::FMT_C4) ? {4'd0, s_nib} : r_s1.d;
        pcount = (i_cfg.pal_count > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH) : i_cfg.pal_count;
        pv = i_cfg.pal_be ? r_pal_q : {r_pal_q[7:0], r_pal_q[15:8]};
        if ({1'b0, lidx} < pcount && i_cfg.pal_fmt != 2'd3) begin
            unique case (i_cfg.pal_fmt)
                2'd2: pc = dec5a3(pv);
                2'd1: pc = dec565(pv);
                default: pc = '{r: pv[7:0], g: pv[7:0], b: pv[7:0], a: pv[15:8]};
            endcase
        end else begin
            pc = '{r: lidx, g: lidx, b: lidx, a: 8'hFF};
        end

        v16 = {r_s1.held, r_s1.d};
        c0 = dec565(r_s1.e0);
        c1 = dec565(r_s1.e1);
        unique case (r_s1_k)
            2'd0: cidx = r_s1.d[7:6];
            2'd1: cidx = r_s1.d[5:4];
            2'd2: cidx = r_s1.d[3:2];
            default: cidx = r_s1.d[1:0];
        endcase

        unique case (r_s1.fmt)
            ttd_pkg::FMT_I4: c = '{r: {s_nib, s_nib}, g: {s_nib, s_nib},
                                   b: {s_nib, s_nib}, a: {s_nib, s_nib}};
            ttd_pkg::FMT_I8: c = '{r: r_s1.d, g: r_s1.d, b: r_s1.d, a: r_s1.d};
            ttd_pkg::FMT_IA4: c = '{r: {r_s1.d[3:0], r_s1.d[3:0]},
                                    g: {r_s1.d[3:0], r_s1.d[3:0]},
                                    b: {r_s1.d[3:0], r_s1.d[3:0]},
                                    a: {r_s1.d[7:4], r_s1.d[7:4]}};
            ttd_pkg::FMT_IA8: c = '{r: r_s1.d, g: r_s1.d, b: r_s1.d, a: r_s1.held};
            ttd_pkg::FMT_RGB565: c = dec565(v16);
            ttd_pkg::FMT_RGB5A3: c = dec5a3(v16);
            ttd_pkg::FMT_RGBA8: c = '{r: r_s1.aux[7:0], g: r_s1.held, b: r_s1.d,
                                      a: r_s1.aux[15:8]};
            ttd_pkg::FMT_C4, ttd_pkg::FMT_C8: c = pc;
            ttd_pkg::FMT_CMPR: begin
                if (cidx == 2'd0) begin
                    c = c0;
                end else if (cidx == 2'd1) begin
                    c = c1;
                end else if (r_s1.e0 > r_s1.e1) begin
                    if (cidx == 2'd2) begin
                        c = '{r: blend(c0.r, c1.r), g: blend(c0.g, c1.g),
                              b: blend(c0.b, c1.b), a: 8'hFF};
                    end else begin
                        c = '{r: blend(c1.r, c0.r), g: blend(c1.g, c0.g),
                              b: blend(c1.b, c0.b), a: 8'hFF};
                    end
                end else begin
                    c = '{r: avg(c0.r, c1.r), g: avg(c0.g, c1.g), b: avg(c0.b, c1.b),
                          a: (cidx == 2'd2) ? 8'hFF : 8'h00};
                end
            end
            default: c = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
            r_s1_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_q_pop) begin
                r_mask <= i_q_job.is_wr ? 4'd0 : i_q_job.mask;
            end else if (take) begin
                r_mask <= rest;
            end
            if (take) begin
                r_s1_v <= 1'b1;
            end else if (s1_move) begin
                r_s1_v <= 1'b0;
            end
            if (s1_move) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop && !i_q_job.is_wr) begin
            r_job <= i_q_job;
        end
        if (take) begin
            r_s1 <= s1_job;
            r_s1_k <= k;
            r_s1_last <= (rest == '0);
        end
        if (s1_move) begin
            r_out_data <= {4'd0, c.a, c.b, c.g, c.r, r_s1.y[9:0], r_s1.x[9:0]};
            r_out_last <= r_s1_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pal_q <= r_pal[pidx[PAW-1:0]];
        end
        if (o_q_pop && i_q_job.is_wr) begin
            r_pal[i_q_job.idx[PAW-1:0]] <= i_q_job.aux;
        end
    end

    assign o_valid = r_out_v;
    assign o_data = r_out_data;
    assign o_last = r_out_last;

endmodule

>>> hdl/tiled_texture_decoder.sv
`timescale 1ns / 1ps
// Path: accepted bytes pass the queue, job, stage-1 and output registers.
// Throughput: one byte per cycle in while not full; the back end emits one pixel
// per cycle while ready, so sustained I4, C4 and compressed row bytes stall input.
// Reset: synchronous, active low; clears config, walk state and queue.
// Palette and RGBA8 buffer contents are kept and hold nothing until written.
module tiled_texture_decoder #(
    parameter int MAX_DIMENSION = ttd_pkg::MAX_DIM_DEF,
    parameter int PALETTE_DEPTH = ttd_pkg::PAL_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [10:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte, extra_byte, entry_index
    input  logic [23:0] s_axis_tdata,
    // command
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_x, pixel_y, red, green, blue, alpha, 4 zero bits
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tlast
);
    ttd_pkg::t_cfg r_cfg;
    ttd_pkg::t_job f_job, q_job;
    logic          accept, q_push, q_pop, q_full, q_empty;

    assign s_axis_tready = !q_full;
    assign accept = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt <= ttd_pkg::FMT_I4;
            r_cfg.width <= 11'd1;
            r_cfg.height <= 11'd1;
            r_cfg.pal_fmt <= 2'd0;
            r_cfg.pal_count <= 9'd0;
            r_cfg.pal_be <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ttd_pkg::REG_TEX_FMT:   r_cfg.fmt <= i_cfg_data[3:0];
                ttd_pkg::REG_WIDTH:     r_cfg.width <= i_cfg_data;
                ttd_pkg::REG_HEIGHT:    r_cfg.height <= i_cfg_data;
                ttd_pkg::REG_PAL_FMT:   r_cfg.pal_fmt <= i_cfg_data[1:0];
                ttd_pkg::REG_PAL_COUNT: r_cfg.pal_count <= i_cfg_data[8:0];
                ttd_pkg::REG_PAL_BE:    r_cfg.pal_be <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    ttd_front #(
        .MAX_DIMENSION(MAX_DIMENSION),
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_accept (accept),
        .i_cmd    (s_axis_tuser),
        .i_data   (s_axis_tdata[7:0]),
        .i_extra  (s_axis_tdata[15:8]),
        .i_index  (s_axis_tdata[23:16]),
        .o_push   (q_push),
        .o_job    (f_job)
    );

    ttd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (f_job),
        .i_pop   (q_pop),
        .o_job   (q_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ttd_back #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_valid (!q_empty),
        .i_q_job   (q_job),
        .o_q_pop   (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full) else $error("queue push while full");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty) else $error("queue pop while empty");
    a_last_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_empty && !q_push && m_axis_tvalid && m_axis_tready && !m_axis_tlast)
        |=> !(q_empty && !m_axis_tvalid && !q_push))
        else $error("run ended without last");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;

    typedef struct {
        logic [9:0] px;
        logic [9:0] py;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       last;
    } t_pixel;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] d;
        logic [7:0] e;
        logic [7:0] idx;
        int         check_r;
        int         check_a;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [10:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    tiled_texture_decoder DUT (.*);

    always #10 i_clk = ~i_clk;

    logic [3:0]  tex_fmt;
    logic [10:0] img_w;
    logic [10:0] img_h;
    logic [1:0]  pal_fmt;
    logic [8:0]  pal_cnt;
    logic        pal_be;
    int unsigned blk_col, blk_row, blk_byte;
    logic [7:0]  held;
    logic [15:0] endpoints [2];
    logic [15:0] ar_buf [16];
    logic [15:0] pal_mem [256];

    t_pixel      pending_pixels [$];
    int          mismatches = 0;
    longint      cycles = 0;
    bit          sink_calm = 1'b0;
    bit          src_calm = 1'b0;
    bit          done = 1'b0;

    function automatic logic [7:0] ext5(logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic t_pixel mkpix(int r, int g, int b, int a);
        t_pixel p;
        p.r = r[7:0]; p.g = g[7:0]; p.b = b[7:0]; p.a = a[7:0];
        p.px = '0; p.py = '0; p.last = 1'b0;
        return p;
    endfunction

    function automatic t_pixel rgb565_pixel(logic [15:0] v);
        return mkpix(ext5(v[15:11]), {v[10:5], v[10:9]}, ext5(v[4:0]), 255);
    endfunction

    function automatic t_pixel rgb5a3_pixel(logic [15:0] v);
        logic [2:0] a;
        a = v[14:12];
        if (v[15])
            return mkpix(ext5(v[14:10]), ext5(v[9:5]), ext5(v[4:0]), 255);
        return mkpix(v[11:8] * 17, v[7:4] * 17, v[3:0] * 17, {a, a, a[2:1]});
    endfunction

    function automatic t_pixel palette_pixel(int unsigned ix);
        logic [15:0] raw;
        logic [15:0] v;
        if (ix < pal_cnt && pal_fmt <= 2) begin
            raw = pal_mem[ix];
            v = pal_be ? raw : {raw[7:0], raw[15:8]};
            if (pal_fmt == 2) return rgb5a3_pixel(v);
            if (pal_fmt == 1) return rgb565_pixel(v);
            return mkpix(v[7:0], v[7:0], v[7:0], v[15:8]);
        end
        return mkpix(ix, ix, ix, 255);
    endfunction

    function automatic int mix53(int p, int s);
        return ((p * 5 + s * 3) >> 3) & 255;
    endfunction

    function automatic t_pixel dxt_pixel(int ix);
        t_pixel c0;
        t_pixel c1;
        c0 = rgb565_pixel(endpoints[0]);
        c1 = rgb565_pixel(endpoints[1]);
        if (ix == 0) return c0;
        if (ix == 1) return c1;
        if (endpoints[0] > endpoints[1]) begin
            if (ix == 2) return mkpix(mix53(c0.r, c1.r), mix53(c0.g, c1.g), mix53(c0.b, c1.b), 255);
            return mkpix(mix53(c1.r, c0.r), mix53(c1.g, c0.g), mix53(c1.b, c0.b), 255);
        end
        return mkpix((c0.r + c1.r) / 2, (c0.g + c1.g) / 2, (c0.b + c1.b) / 2,
            ix == 2 ? 255 : 0);
    endfunction

    function automatic void put_pixel(int unsigned x, int unsigned y, int unsigned w,
                                      int unsigned h, t_pixel c, inout int n);
        if (x >= w || y >= h) return;
        c.px = x[9:0]; c.py = y[9:0]; c.last = 1'b0;
        pending_pixels.push_back(c);
        n++;
    endfunction

    function automatic void decode_item(logic [1:0] cmd, logic [7:0] d, logic [7:0] e,
                                        logic [7:0] ix);
        int unsigned w, h, bw, bh, sz, b, bx, by, x, y, i, o;
        logic [15:0] v;
        t_pixel c;
        int n;
        n = 0;
        if (cmd == ttd_pkg::CMD_START) begin
            blk_col = 0; blk_row = 0; blk_byte = 0; held = '0;
            endpoints[0] = '0; endpoints[1] = '0;
            return;
        end
        if (cmd == ttd_pkg::CMD_PAL) begin
            pal_mem[ix] = {d, e};
            return;
        end
        if (cmd != ttd_pkg::CMD_BYTE || tex_fmt > ttd_pkg::FMT_CMPR) return;
        w = img_w > 1024 ? 1024 : img_w;
        h = img_h > 1024 ? 1024 : img_h;
        if (w == 0 || h == 0) return;
        if (tex_fmt inside {ttd_pkg::FMT_I4, ttd_pkg::FMT_C4, ttd_pkg::FMT_CMPR}) begin
            bw = 8; bh = 8;
        end else if (tex_fmt inside {ttd_pkg::FMT_I8, ttd_pkg::FMT_IA4, ttd_pkg::FMT_C8}) begin
            bw = 8; bh = 4;
        end else begin
            bw = 4; bh = 4;
        end
        sz = tex_fmt == ttd_pkg::FMT_RGBA8 ? 64 : 32;
        b = blk_byte & (sz - 1);
        bx = blk_col * bw;
        by = blk_row * bh;
        case (tex_fmt)
            ttd_pkg::FMT_I4, ttd_pkg::FMT_C4: begin
                x = bx + (b & 3) * 2; y = by + (b >> 2);
                if (tex_fmt == ttd_pkg::FMT_I4) begin
                    put_pixel(x, y, w, h, mkpix(d[7:4] * 17, d[7:4] * 17, d[7:4] * 17,
                        d[7:4] * 17), n);
                    put_pixel(x + 1, y, w, h, mkpix(d[3:0] * 17, d[3:0] * 17, d[3:0] * 17,
                        d[3:0] * 17), n);
                end else begin
                    put_pixel(x, y, w, h, palette_pixel(d[7:4]), n);
                    put_pixel(x + 1, y, w, h, palette_pixel(d[3:0]), n);
                end
            end
            ttd_pkg::FMT_I8, ttd_pkg::FMT_IA4, ttd_pkg::FMT_C8: begin
                if (tex_fmt == ttd_pkg::FMT_I8) c = mkpix(d, d, d, d);
                else if (tex_fmt == ttd_pkg::FMT_IA4)
                    c = mkpix(d[3:0] * 17, d[3:0] * 17, d[3:0] * 17, d[7:4] * 17);
                else c = palette_pixel(d);
                put_pixel(bx + (b & 7), by + (b >> 3), w, h, c, n);
            end
            ttd_pkg::FMT_IA8, ttd_pkg::FMT_RGB565, ttd_pkg::FMT_RGB5A3: begin
                if ((b & 1) == 0) held = d;
                else begin
                    i = b >> 1;
                    v = {held, d};
                    if (tex_fmt == ttd_pkg::FMT_IA8) c = mkpix(d, d, d, held);
                    else if (tex_fmt == ttd_pkg::FMT_RGB565) c = rgb565_pixel(v);
                    else c = rgb5a3_pixel(v);
                    put_pixel(bx + (i & 3), by + (i >> 2), w, h, c, n);
                end
            end
            ttd_pkg::FMT_RGBA8: begin
                if ((b & 1) == 0) held = d;
                else begin
                    i = (b >> 1) & 15;
                    if (b < 32) ar_buf[i] = {held, d};
                    else begin
                        v = ar_buf[i];
                        put_pixel(bx + (i & 3), by + (i >> 2), w, h,
                            mkpix(v[7:0], held, d, v[15:8]), n);
                    end
                end
            end
            default: begin
                o = b & 7;
                if (o == 0 || o == 2) held = d;
                else if (o == 1 || o == 3) endpoints[o >> 1] = {held, d};
                else begin
                    x = bx + ((b >> 3) & 1) * 4;
                    y = by + ((b >> 3) >> 1) * 4 + (o - 4);
                    for (i = 0; i < 4; i++)
                        put_pixel(x + i, y, w, h, dxt_pixel((d >> (6 - i * 2)) & 3), n);
                end
            end
        endcase
        blk_byte = b + 1;
        if (blk_byte >= sz) begin
            blk_byte = 0;
            blk_col++;
            if (blk_col >= (w + bw - 1) / bw) begin
                blk_col = 0;
                blk_row++;
                if (blk_row >= (h + bh - 1) / bh) blk_row = 0;
            end
        end
        if (n > 0) pending_pixels[pending_pixels.size() - 1].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000 && !done) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) m_axis_tready <= sink_calm ? 1'b1 : ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin
        t_pixel exp_px;
        logic [55:0] got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel %h", got);
            end else begin
                exp_px = pending_pixels.pop_front();
                if (got[9:0] !== exp_px.px || got[19:10] !== exp_px.py ||
                    got[27:20] !== exp_px.r || got[35:28] !== exp_px.g ||
                    got[43:36] !== exp_px.b || got[51:44] !== exp_px.a ||
                    got[55:52] !== 4'd0 || m_axis_tlast !== exp_px.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("pixel: exp x%0d y%0d %h%h%h%h l%b, got %h l%b",
                            exp_px.px, exp_px.py, exp_px.r, exp_px.g, exp_px.b, exp_px.a,
                            exp_px.last, got, m_axis_tlast);
                end
            end
        end
    end

    task automatic set_reg(logic [2:0] idx, int val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            ttd_pkg::REG_TEX_FMT:   tex_fmt = val[3:0];
            ttd_pkg::REG_WIDTH:     img_w = val[10:0];
            ttd_pkg::REG_HEIGHT:    img_h = val[10:0];
            ttd_pkg::REG_PAL_FMT:   pal_fmt = val[1:0];
            ttd_pkg::REG_PAL_COUNT: pal_cnt = val[8:0];
            default:                pal_be = val[0];
        endcase
    endtask

    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic send_item(logic [1:0] cmd, logic [7:0] d, logic [7:0] e, logic [7:0] ix);
        while (!src_calm && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {ix, e, d};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        decode_item(cmd, d, e, ix);
    endtask

    task automatic load_palette(int count);
        for (int k = 0; k < count; k++)
            send_item(ttd_pkg::CMD_PAL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                k[7:0]);
    endtask

    t_row dir_rows [$];
    int   base;

    initial begin
        tex_fmt = ttd_pkg::FMT_I4; img_w = 11'd1; img_h = 11'd1;
        pal_fmt = 2'd0; pal_cnt = 9'd0; pal_be = 1'b1;
        blk_col = 0; blk_row = 0; blk_byte = 0; held = '0;
        endpoints[0] = '0; endpoints[1] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows on a 1x1 image after reset (I4: alpha = intensity)
        dir_rows.push_back('{ttd_pkg::CMD_BYTE, 8'hF0, 8'h00, 8'h00, 255, 255});
        dir_rows.push_back('{ttd_pkg::CMD_START, 8'h00, 8'h00, 8'h00, -1, -1});
        dir_rows.push_back('{ttd_pkg::CMD_BYTE, 8'h0F, 8'h00, 8'h00, 0, 0});
        dir_rows.push_back('{2'd3, 8'hFF, 8'hFF, 8'hFF, -1, -1});
        dir_rows.push_back('{ttd_pkg::CMD_PAL, 8'hAA, 8'h55, 8'hFF, -1, -1});
        foreach (dir_rows[k]) begin
            drain_pixels();
            base = pending_pixels.size();
            send_item(dir_rows[k].cmd, dir_rows[k].d, dir_rows[k].e, dir_rows[k].idx);
            if (dir_rows[k].check_r >= 0 && (pending_pixels.size() != base + 1 ||
                pending_pixels[base].r != dir_rows[k].check_r ||
                pending_pixels[base].a != dir_rows[k].check_a)) begin
                mismatches++;
                $display("directed row %0d predicted wrong", k);
            end
        end
        drain_pixels();

        load_palette(16);
        drain_pixels();
        for (int f = 0; f <= 11; f++) begin
            set_reg(ttd_pkg::REG_TEX_FMT, f);
            set_reg(ttd_pkg::REG_WIDTH, (f == 3) ? 1024 : (f == 10) ? 0 : $urandom_range(1, 12));
            set_reg(ttd_pkg::REG_HEIGHT, (f == 3) ? 2047 : $urandom_range(1, 10));
            set_reg(ttd_pkg::REG_PAL_FMT, f % 4);
            set_reg(ttd_pkg::REG_PAL_COUNT, (f == 8) ? 0 : (f == 7) ? 16 : $urandom_range(0, 16));
            set_reg(ttd_pkg::REG_PAL_BE, f & 1);
            src_calm = (f == 4);
            sink_calm = (f == 4);
            send_item(ttd_pkg::CMD_START, 8'd0, 8'd0, 8'd0);
            for (int k = 0; k < 6 + (f == 6 ? 34 : 0) + (f == 9 ? 6 : 0) + (f == 4 ? 10 : 0);
                 k++) begin
                if ($urandom_range(99) < 3) send_item(2'($urandom_range(3)),
                    8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(15)));
                else send_item(ttd_pkg::CMD_BYTE, 8'($urandom_range(255)), 8'd0, 8'd0);
            end
            drain_pixels();
        end
        // widest image with the full palette count; index only loaded entries
        set_reg(ttd_pkg::REG_PAL_COUNT, 256);
        set_reg(ttd_pkg::REG_PAL_FMT, 1);
        set_reg(ttd_pkg::REG_TEX_FMT, ttd_pkg::FMT_C8);
        set_reg(ttd_pkg::REG_WIDTH, 2047);
        set_reg(ttd_pkg::REG_HEIGHT, 1);
        send_item(ttd_pkg::CMD_START, 8'd0, 8'd0, 8'd0);
        for (int k = 0; k < 16; k++)
            send_item(ttd_pkg::CMD_BYTE, 8'($urandom_range(15)), 8'd0, 8'd0);
        drain_pixels();

        done = 1'b1;
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
